@@ rtl/esm_pkg.sv @@
package esm_pkg;

  localparam int IDX_W       = 10;
  localparam int VAL_W       = 32;
  localparam int LEN_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0]     LEN_RESET          = 11'd1024;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_MODE = 1'b1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ENTRY,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    err;
    logic [IDX_W-1:0]        x_addr;
    logic [IDX_W-1:0]        y_addr;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_MUL,
    ST_ACC,
    ST_READ
  } back_state_t;

endpackage

@@ rtl/esm_ram.sv @@
module esm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/esm_front.sv @@
module esm_front import esm_pkg::*; #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op,
  input  logic [IDX_W-1:0]     row_index,
  input  logic [IDX_W-1:0]     col_index,
  input  logic signed [VAL_W-1:0] value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  input  logic                 queue_space,
  input  logic                 back_open,
  output logic                 push,
  output cmd_t                 cmd
);

  logic [LEN_W-1:0] active_length;
  logic             transpose_mode;
  logic             row_ok;
  logic             col_ok;

  function automatic logic in_range(input logic [IDX_W-1:0] idx,
                                    input logic [LEN_W-1:0] len);
    return ({1'b0, idx} < len) && (32'(idx) < 32'(VECTOR_DEPTH));
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = queue_space && back_open;
  assign push      = in_valid && in_ready;
  assign row_ok    = in_range(row_index, active_length);
  assign col_ok    = in_range(col_index, active_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length  <= LEN_RESET;
      transpose_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_LENGTH:  active_length  <= cfg_data;
        CFG_TRANSPOSE_MODE: transpose_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_NOP;
    cmd.value  = value;
    cmd.x_addr = row_index;
    cmd.y_addr = row_index;
    case (op)
      OP_LOAD: begin
        if (row_ok) begin
          cmd.kind = CMD_LOAD;
        end else begin
          cmd.err = 1'b1;
        end
      end
      OP_ENTRY: begin
        if (row_ok && col_ok) begin
          cmd.kind = CMD_ENTRY;
          if (transpose_mode) begin
            cmd.x_addr = row_index;
            cmd.y_addr = col_index;
          end else begin
            cmd.x_addr = col_index;
            cmd.y_addr = row_index;
          end
        end else begin
          cmd.err = 1'b1;
        end
      end
      OP_CLEAR: cmd.kind = CMD_CLEAR;
      OP_READ: begin
        cmd.kind = CMD_READ;
        cmd.err  = !row_ok;
      end
      default: cmd.kind = CMD_NOP;
    endcase
  end

endmodule

@@ rtl/esm_queue.sv @@
module esm_queue import esm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic space,
  input  logic pop,
  output cmd_t head,
  output logic head_valid
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign space      = count != CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> space) else $error("word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("word popped from empty queue");

endmodule

@@ rtl/esm_back.sv @@
module esm_back import esm_pkg::*; #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    head,
  input  logic                    head_valid,
  output logic                    pop,
  output logic                    open,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] result_value,
  output logic [IDX_W-1:0]        result_index,
  output logic                    index_error,
  output logic                    overflow
);

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int LW = AW + IDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(VECTOR_DEPTH - 1);
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  back_state_t state;
  back_state_t state_next;
  logic [AW-1:0] sweep_addr;
  logic          err_flag;
  logic          ovf_flag;
  cmd_t          cur;
  logic signed [63:0]      prod;
  logic signed [VAL_W-1:0] acc;

  logic              x_we;
  logic [AW-1:0]     x_waddr;
  logic [AW-1:0]     x_raddr;
  logic [VAL_W-1:0]  x_rdata;
  logic              y_we;
  logic [AW-1:0]     y_waddr;
  logic [VAL_W-1:0]  y_wdata;
  logic [AW-1:0]     y_raddr;
  logic [VAL_W-1:0]  y_rdata;

  logic signed [63:0]      shifted;
  logic signed [63:0]      sum;
  logic signed [VAL_W-1:0] sat_sum;
  logic                    sat_hit;

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [LW-1:0] w;
    w = LW'(idx);
    return w[AW-1:0];
  endfunction

  esm_ram #(.WIDTH(VAL_W), .DEPTH(VECTOR_DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (head.value),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  esm_ram #(.WIDTH(VAL_W), .DEPTH(VECTOR_DEPTH)) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (y_waddr),
    .wdata (y_wdata),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  assign pop = (state == ST_IDLE) && head_valid
               && !((head.kind == CMD_READ) && out_valid);

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          case (head.kind)
            CMD_ENTRY: state_next = ST_MUL;
            CMD_CLEAR: state_next = ST_SWEEP;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    shifted = prod >>> FRAC_BITS;
    sum     = 64'(acc) + shifted;
    sat_hit = 1'b0;
    sat_sum = sum[VAL_W-1:0];
    if (sum > SAT_MAX) begin
      sat_sum = SAT_MAX[VAL_W-1:0];
      sat_hit = 1'b1;
    end else if (sum < SAT_MIN) begin
      sat_sum = SAT_MIN[VAL_W-1:0];
      sat_hit = 1'b1;
    end
  end

  always_comb begin
    x_we    = pop && (head.kind == CMD_LOAD);
    x_waddr = to_addr(head.x_addr);
    x_raddr = to_addr(head.x_addr);
    y_raddr = to_addr(head.y_addr);
    y_we    = 1'b0;
    y_waddr = sweep_addr;
    y_wdata = '0;
    case (state)
      ST_SWEEP: y_we = 1'b1;
      ST_ACC: begin
        y_we    = 1'b1;
        y_waddr = to_addr(cur.y_addr);
        y_wdata = sat_sum;
      end
      default: y_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      open       <= 1'b0;
      err_flag   <= 1'b0;
      ovf_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + 1'b1;
        if (sweep_addr == LAST_ADDR) begin
          open <= 1'b1;
        end
      end
      if (pop) begin
        if (head.kind == CMD_CLEAR) begin
          err_flag <= 1'b0;
          ovf_flag <= 1'b0;
        end else if (head.err) begin
          err_flag <= 1'b1;
        end
      end
      if ((state == ST_ACC) && sat_hit) begin
        ovf_flag <= 1'b1;
      end
      if (state == ST_READ) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_MUL) begin
      prod <= 64'($signed(x_rdata)) * 64'($signed(cur.value));
      acc  <= $signed(y_rdata);
    end
    if (state == ST_READ) begin
      result_value <= cur.err ? '0 : $signed(y_rdata);
      result_index <= cur.y_addr;
      index_error  <= err_flag;
      overflow     <= ovf_flag;
    end
  end

  a_read_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> out_valid) else $error("read word not presented");

  a_read_waits_out: assert property (@(posedge clk) disable iff (rst)
    (pop && (head.kind == CMD_READ)) |-> !out_valid)
    else $error("read started over pending result");

  a_closed_during_init: assert property (@(posedge clk) disable iff (rst)
    !open |-> !head_valid) else $error("word queued before initial sweep ended");

endmodule

@@ rtl/ell_sparse_matvec_unit.sv @@
// Sparse matrix-vector engine, Q16.16, ELLPACK entry stream.
// Input channel (in_valid/in_ready): one word per op - load x element,
// apply matrix entry, clear y and flags, read y element.
// Output channel (out_valid/out_ready): one word per read, carrying the
// y value, its index and the sticky index_error and overflow flags.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets
// active_length, index 1 sets transpose_mode; write only while idle.
// Words pass through a two-entry queue into a sequencer that owns the
// x and y memories. Per word in the sequencer: load and no-op finish as
// the word is taken, matrix entry steps through memory read, 32x32
// multiply, then saturating add and write back, read passes the read
// state into the output register, and clear takes the word, then zeroes
// one y memory row per cycle. After reset the y memory is swept to zero
// with in_ready low; the configuration port accepts writes throughout.
// A read waits while the output register still holds an untaken word;
// words behind it wait too, and the queue absorbs input until full.
module ell_sparse_matvec_unit import esm_pkg::*; #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              op,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] result_value,
  output logic [IDX_W-1:0]        result_index,
  output logic                    index_error,
  output logic                    overflow,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [LEN_W-1:0]        cfg_data
);

  logic push;
  cmd_t push_cmd;
  logic space;
  logic pop;
  cmd_t head;
  logic head_valid;
  logic open;

  esm_front #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .row_index   (row_index),
    .col_index   (col_index),
    .value       (value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .queue_space (space),
    .back_open   (open),
    .push        (push),
    .cmd         (push_cmd)
  );

  esm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .space      (space),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  esm_back #(.VECTOR_DEPTH(VECTOR_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .open         (open),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_index (result_index),
    .index_error  (index_error),
    .overflow     (overflow)
  );

endmodule
